// ===== hdl/wrse_pkg.sv =====
// Package: types, codes and constants of the weekly radio schedule evaluator.
package wrse_pkg;

    localparam int ENTRIES    = 8;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int TIME_W     = 17;
    localparam int DAYS_W     = 7;
    localparam int WDAY_W     = 3;
    localparam int ACT_W      = 2;
    localparam int CMD_W      = 2;
    localparam int EIDX_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [TIME_W-1:0] DAY_SECONDS   = TIME_W'(86400);
    localparam logic [TIME_W-1:0] MAX_TIME      = TIME_W'(86399);
    localparam logic [TIME_W-1:0] BAD_TIME_WAIT = TIME_W'(5 * 60);
    localparam logic [TIME_W-1:0] NO_CLOCK_WAIT = TIME_W'(45);
    localparam logic [TIME_W-1:0] NEXT_MARGIN   = TIME_W'(5);
    localparam logic [WDAY_W-1:0] LAST_WEEKDAY  = WDAY_W'(6);

    localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_EVAL   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MANUAL = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [CMD_W-1:0] CMD_ON   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OFF  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HOLD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SCHED_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 1'd1;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [EIDX_W-1:0] entry_index;
        logic [TIME_W-1:0] on_time;
        logic [DAYS_W-1:0] on_days;
        logic [TIME_W-1:0] off_time;
        logic [DAYS_W-1:0] off_days;
        logic [WDAY_W-1:0] weekday;
        logic [TIME_W-1:0] seconds_of_day;
        logic              clock_valid;
    } t_in_item;

    typedef struct packed {
        logic [CMD_W-1:0]  radio_command;
        logic [TIME_W-1:0] recheck_seconds;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic [TIME_W-1:0] on_time;
        logic [DAYS_W-1:0] on_days;
        logic [TIME_W-1:0] off_time;
        logic [DAYS_W-1:0] off_days;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_TD,
        S_SCAN_YD,
        S_DECIDE,
        S_EMIT
    } t_state;

    function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W-1:0] t);
        return (t > MAX_TIME) ? MAX_TIME : t;
    endfunction

endpackage

// ===== hdl/wrse_in_if.sv =====
// Interface: input item channel.
interface wrse_in_if;
    logic               valid;
    logic               ready;
    wrse_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/wrse_out_if.sv =====
// Interface: result item channel.
interface wrse_out_if;
    logic                valid;
    logic                ready;
    wrse_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/wrse_cfg_if.sv =====
// Interface: configuration write channel.
interface wrse_cfg_if;
    logic                 valid;
    logic                 ready;
    wrse_pkg::t_cfg_write data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/weekly_radio_schedule_evaluator.sv =====
// Top level: weekly radio schedule evaluator with a sequenced scan over the entry table.
//
// Channels: i_item takes transactions (write entry, evaluate, note manual change);
// o_result gives one transaction per evaluate; i_cfg writes schedule_enable (index 0)
// and entry_count (index 1) and is always ready.
// Write, manual-change and unused actions give no result.
// An evaluate that ends early (schedule off or no entries, clock not synchronized,
// bad time) goes from idle straight to the emit step and the output register. A full
// evaluate walks the table with one shared compare unit, one time slot (on or off of
// one entry) per cycle, over the first min(entry_count, 8) entries: today's slots,
// then yesterday's slots when today has no past time, then one decide step and the
// emit step into the output register.
// i_item.ready is high only while the sequencer is idle.
// The output register holds a result until taken; a stalled receiver stops the
// sequencer at its last step, so no result is lost.
// Reset clears the table, the event latch, the hold flag and both registers.
module weekly_radio_schedule_evaluator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wrse_in_if.sink           i_item,
    wrse_out_if.source        o_result,
    wrse_cfg_if.sink          i_cfg
);

    wrse_pkg::t_state r_state, n_state;

    wrse_pkg::t_entry r_table [wrse_pkg::ENTRIES];
    wrse_pkg::t_entry n_table [wrse_pkg::ENTRIES];

    logic                              r_sched_en;
    logic [wrse_pkg::CFG_DATA_W-1:0]   r_entry_count;

    logic                              r_lvalid, n_lvalid;
    logic [wrse_pkg::WDAY_W-1:0]       r_lday, n_lday;
    logic [wrse_pkg::TIME_W-1:0]       r_lsec, n_lsec;
    logic                              r_hold, n_hold;

    logic [wrse_pkg::WDAY_W-1:0]       r_wday, n_wday;
    logic [wrse_pkg::WDAY_W-1:0]       r_yday, n_yday;
    logic [wrse_pkg::TIME_W-1:0]       r_cur, n_cur;
    logic [wrse_pkg::IDX_W:0]          r_slot, n_slot;
    logic [wrse_pkg::IDX_W-1:0]        r_last, n_last;
    logic                              r_use_yd, n_use_yd;
    logic                              r_hp_on, n_hp_on;
    logic                              r_hp_off, n_hp_off;
    logic [wrse_pkg::TIME_W-1:0]       r_p_on, n_p_on;
    logic [wrse_pkg::TIME_W-1:0]       r_p_off, n_p_off;
    logic                              r_hn, n_hn;
    logic [wrse_pkg::TIME_W-1:0]       r_next, n_next;

    wrse_pkg::t_out_item               r_res, n_res;
    logic                              r_out_valid, n_out_valid;
    wrse_pkg::t_out_item               r_out, n_out;

    wrse_pkg::t_entry                  scan_ent;
    logic                              scan_sel;
    logic [wrse_pkg::TIME_W-1:0]       scan_t;
    logic [wrse_pkg::DAYS_W-1:0]       scan_days;
    logic [wrse_pkg::WDAY_W-1:0]       scan_day;
    logic                              scan_en;
    logic                              scan_is_past;
    logic                              scan_better_past;
    logic                              scan_better_next;
    logic                              take_past;
    logic                              take_next;
    logic                              last_slot;

    logic                              has_past;
    logic                              on_wins;
    logic [wrse_pkg::TIME_W-1:0]       ev_t;
    logic [wrse_pkg::WDAY_W-1:0]       ev_day;
    logic                              ev_differ;
    logic [wrse_pkg::CMD_W-1:0]        sched_cmd;
    logic [wrse_pkg::TIME_W-1:0]       wait_base;

    assign i_item.ready   = (r_state == wrse_pkg::S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // Shared compare unit: one time slot per cycle.
    assign scan_ent         = r_table[r_slot[wrse_pkg::IDX_W:1]];
    assign scan_sel         = r_slot[0];
    assign scan_t           = scan_sel ? scan_ent.off_time : scan_ent.on_time;
    assign scan_days        = scan_sel ? scan_ent.off_days : scan_ent.on_days;
    assign scan_day         = (r_state == wrse_pkg::S_SCAN_YD) ? r_yday : r_wday;
    assign scan_en          = scan_days[scan_day];
    assign scan_is_past     = (r_cur >= scan_t);
    assign scan_better_past = scan_sel ? (!r_hp_off || scan_t > r_p_off)
                                       : (!r_hp_on || scan_t > r_p_on);
    assign scan_better_next = !r_hn || (scan_t < r_next);
    assign take_past        = scan_en && scan_better_past &&
                              (scan_is_past || r_state == wrse_pkg::S_SCAN_YD);
    assign take_next        = scan_en && !scan_is_past && scan_better_next &&
                              (r_state == wrse_pkg::S_SCAN_TD);
    assign last_slot        = (r_slot == {r_last, 1'b1});

    assign has_past  = r_hp_on || r_hp_off;
    assign on_wins   = r_hp_on && (!r_hp_off || r_p_on >= r_p_off);
    assign ev_t      = on_wins ? r_p_on : r_p_off;
    assign ev_day    = r_use_yd ? r_yday : r_wday;
    assign ev_differ = r_lvalid && ((r_lday != ev_day) || (r_lsec != ev_t));
    assign sched_cmd = on_wins ? wrse_pkg::CMD_ON : wrse_pkg::CMD_OFF;
    assign wait_base = r_hn ? r_next : wrse_pkg::DAY_SECONDS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrse_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_table     = r_table;
        n_lvalid    = r_lvalid;
        n_lday      = r_lday;
        n_lsec      = r_lsec;
        n_hold      = r_hold;
        n_wday      = r_wday;
        n_yday      = r_yday;
        n_cur       = r_cur;
        n_slot      = r_slot;
        n_last      = r_last;
        n_use_yd    = r_use_yd;
        n_hp_on     = r_hp_on;
        n_hp_off    = r_hp_off;
        n_p_on      = r_p_on;
        n_p_off     = r_p_off;
        n_hn        = r_hn;
        n_next      = r_next;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_result.ready;

        unique case (r_state)
            wrse_pkg::S_IDLE: begin
                if (i_item.valid) begin
                    case (i_item.data.action)
                        wrse_pkg::ACT_WRITE: begin
                            if (32'(i_item.data.entry_index) < wrse_pkg::ENTRIES) begin
                                n_table[wrse_pkg::IDX_W'(i_item.data.entry_index)] = '{
                                    on_time:  wrse_pkg::sat_time(i_item.data.on_time),
                                    on_days:  i_item.data.on_days,
                                    off_time: wrse_pkg::sat_time(i_item.data.off_time),
                                    off_days: i_item.data.off_days
                                };
                            end
                            n_lvalid = 1'b0;
                        end
                        wrse_pkg::ACT_MANUAL: begin
                            n_hold = 1'b1;
                        end
                        wrse_pkg::ACT_EVAL: begin
                            n_wday   = i_item.data.weekday;
                            n_yday   = (i_item.data.weekday == '0) ? wrse_pkg::LAST_WEEKDAY
                                                                   : i_item.data.weekday - 3'd1;
                            n_cur    = i_item.data.seconds_of_day;
                            n_slot   = '0;
                            n_use_yd = 1'b0;
                            n_hp_on  = 1'b0;
                            n_hp_off = 1'b0;
                            n_hn     = 1'b0;
                            n_last   = (32'(r_entry_count) > wrse_pkg::ENTRIES)
                                     ? wrse_pkg::IDX_W'(wrse_pkg::ENTRIES - 1)
                                     : wrse_pkg::IDX_W'(r_entry_count - 4'd1);
                            n_state  = wrse_pkg::S_EMIT;
                            if (!r_sched_en || r_entry_count == '0) begin
                                n_res = '{radio_command: wrse_pkg::CMD_ON,
                                          recheck_seconds: wrse_pkg::NO_CLOCK_WAIT};
                            end else if (!i_item.data.clock_valid) begin
                                n_res = '{radio_command: wrse_pkg::CMD_HOLD,
                                          recheck_seconds: wrse_pkg::NO_CLOCK_WAIT};
                            end else if (i_item.data.seconds_of_day > wrse_pkg::DAY_SECONDS ||
                                         i_item.data.weekday > wrse_pkg::LAST_WEEKDAY) begin
                                n_res = '{radio_command: wrse_pkg::CMD_HOLD,
                                          recheck_seconds: wrse_pkg::BAD_TIME_WAIT};
                            end else begin
                                n_state = wrse_pkg::S_SCAN_TD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            wrse_pkg::S_SCAN_TD, wrse_pkg::S_SCAN_YD: begin
                if (take_past) begin
                    if (scan_sel) begin
                        n_p_off  = scan_t;
                        n_hp_off = 1'b1;
                    end else begin
                        n_p_on  = scan_t;
                        n_hp_on = 1'b1;
                    end
                end
                if (take_next) begin
                    n_next = scan_t;
                    n_hn   = 1'b1;
                end
                n_slot = r_slot + 1'b1;
                if (last_slot) begin
                    if (r_state == wrse_pkg::S_SCAN_TD && !(n_hp_on || n_hp_off)) begin
                        n_slot   = '0;
                        n_use_yd = 1'b1;
                        n_state  = wrse_pkg::S_SCAN_YD;
                    end else begin
                        n_state = wrse_pkg::S_DECIDE;
                    end
                end
            end
            wrse_pkg::S_DECIDE: begin
                n_res.recheck_seconds = wait_base - r_cur + wrse_pkg::NEXT_MARGIN;
                if (has_past) begin
                    n_lvalid = 1'b1;
                    n_lday   = ev_day;
                    n_lsec   = ev_t;
                    if (ev_differ) begin
                        n_hold              = 1'b0;
                        n_res.radio_command = sched_cmd;
                    end else begin
                        n_res.radio_command = r_hold ? wrse_pkg::CMD_HOLD : sched_cmd;
                    end
                end else begin
                    n_res.radio_command = r_hold ? wrse_pkg::CMD_HOLD : wrse_pkg::CMD_ON;
                    if (!r_lvalid) begin
                        n_lvalid = 1'b1;
                        n_lday   = r_wday;
                        n_lsec   = r_cur;
                    end
                end
                n_state = wrse_pkg::S_EMIT;
            end
            wrse_pkg::S_EMIT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = wrse_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wrse_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < wrse_pkg::ENTRIES; k++) begin
                r_table[k] <= '0;
            end
            r_sched_en    <= 1'b0;
            r_entry_count <= '0;
            r_lvalid      <= 1'b0;
            r_lday        <= '0;
            r_lsec        <= '0;
            r_hold        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_table     <= n_table;
            r_lvalid    <= n_lvalid;
            r_lday      <= n_lday;
            r_lsec      <= n_lsec;
            r_hold      <= n_hold;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    wrse_pkg::REG_SCHED_ENABLE: r_sched_en    <= i_cfg.data.data[0];
                    wrse_pkg::REG_ENTRY_COUNT:  r_entry_count <= i_cfg.data.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wday   <= n_wday;
        r_yday   <= n_yday;
        r_cur    <= n_cur;
        r_slot   <= n_slot;
        r_last   <= n_last;
        r_use_yd <= n_use_yd;
        r_hp_on  <= n_hp_on;
        r_hp_off <= n_hp_off;
        r_p_on   <= n_p_on;
        r_p_off  <= n_p_off;
        r_hn     <= n_hn;
        r_next   <= n_next;
        r_res    <= n_res;
        r_out    <= n_out;
    end

endmodule
